>>> rtl/dlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types, codes and constants of the DHCP lease table.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int LEASE_COUNT_DEFAULT = 12;

  localparam int TIME_W    = 48;
  localparam int KEY_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MSG_W     = 8;
  localparam int LIDX_W    = 4;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFER_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEASE_SPAN     = 2'd2;

  localparam logic [CFG_W-1:0] OFFER_HOLD_RESET = 32'd10000;
  localparam logic [CFG_W-1:0] LEASE_SPAN_RESET = 32'd86400000;

  // Message types.
  localparam logic [MSG_W-1:0] MSG_DISCOVER = 8'd1;
  localparam logic [MSG_W-1:0] MSG_REQUEST  = 8'd3;

  // Reply kinds.
  localparam logic [KIND_W-1:0] KIND_NACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;

  // Entry status codes.
  localparam logic [STATUS_W-1:0] ST_AVAIL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OFFER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACK   = 2'd2;

  // Operations of the shared arithmetic unit.
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_EQ  = 2'd0;
  localparam alu_op_t ALU_LT  = 2'd1;
  localparam alu_op_t ALU_SAT = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   expiry;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    host;
  } entry_t;

  typedef struct packed {
    logic              flag;
    logic [TIME_W-1:0] sum;
  } alu_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_live;
  } mem_ctl_t;

endpackage

>>> rtl/dhcp_lease_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_lease_table
// Lease bookkeeping of a small DHCP server: client lookup, expiry sweep,
// offer and acknowledge of lease entries.
// ----------------------------------------------------------------------------
// The block takes one parsed client message at a time and keeps in_stall
// high until its reply is placed in the output register. A message that is
// not a boot request with a type option is dropped. Otherwise the lease
// memory is read one entry per cycle through its single read port: a
// message whose client key sits in entry i ends the key scan at that entry,
// while a miss scans every entry and then runs a full expiry sweep. A
// finished reply waits in the output register while the next message is
// taken in.
// Configuration writes are always accepted and should be made while idle.
module dhcp_lease_table #(
  parameter int LEASE_COUNT = dlt_pkg::LEASE_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlt_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            is_request,
  input  logic                            has_type,
  input  logic [dlt_pkg::MSG_W-1:0]       message_code,
  input  logic [dlt_pkg::KEY_W-1:0]       mac_key,
  input  logic [dlt_pkg::KEY_W-1:0]       host_key,
  input  logic [dlt_pkg::TIME_W-1:0]      now,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dlt_pkg::KIND_W-1:0]      reply_kind,
  output logic                            lease_valid,
  output logic [dlt_pkg::LIDX_W-1:0]      lease_index,
  output logic [dlt_pkg::CFG_W-1:0]       client_address
);
  import dlt_pkg::*;

  localparam int IDX_W = (LEASE_COUNT > 1) ? $clog2(LEASE_COUNT) : 1;

  logic [CFG_W-1:0]  server_address;
  logic [CFG_W-1:0]  offer_hold;
  logic [CFG_W-1:0]  lease_span;

  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  entry_t            mem_rd_data;
  alu_op_t           alu_op;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  alu_res_t          alu_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_address <= '0;
      offer_hold     <= OFFER_HOLD_RESET;
      lease_span     <= LEASE_SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SERVER_ADDRESS: server_address <= cfg_data;
        REG_OFFER_HOLD:     offer_hold     <= cfg_data;
        REG_LEASE_SPAN:     lease_span     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dlt_ctrl #(
    .LEASE_COUNT(LEASE_COUNT)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .server_address (server_address),
    .offer_hold     (offer_hold),
    .lease_span     (lease_span),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .is_request     (is_request),
    .has_type       (has_type),
    .message_code   (message_code),
    .mac_key        (mac_key),
    .host_key       (host_key),
    .now            (now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reply_kind     (reply_kind),
    .lease_valid    (lease_valid),
    .lease_index    (lease_index),
    .client_address (client_address),
    .mem_ctl        (mem_ctl),
    .mem_rd_addr    (mem_rd_addr),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_data    (mem_rd_data),
    .alu_op         (alu_op),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_res        (alu_res)
  );

  dlt_entry_mem #(
    .LEASE_COUNT(LEASE_COUNT)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  dlt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

endmodule

>>> rtl/dlt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_alu
// Shared 48-bit unit: equality, less-than and saturating addition.
// ----------------------------------------------------------------------------
module dlt_alu (
  input  dlt_pkg::alu_op_t                op,
  input  logic [dlt_pkg::TIME_W-1:0]      a,
  input  logic [dlt_pkg::TIME_W-1:0]      b,
  output dlt_pkg::alu_res_t               res
);
  import dlt_pkg::*;

  logic [TIME_W:0] wide_sum;

  assign wide_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res.flag = 1'b0;
    res.sum  = '0;
    case (op)
      ALU_EQ: begin
        res.flag = (a == b);
      end
      ALU_LT: begin
        res.flag = (a < b);
      end
      ALU_SAT: begin
        // A carry out of the time field clamps to the largest time.
        res.sum = wide_sum[TIME_W] ? '1 : wide_sum[TIME_W-1:0];
      end
      default: begin
        res.flag = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/dlt_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_entry_mem
// Lease entry storage with one registered read port, one write port and
// a live bit per entry; an entry that is not live reads as a free entry.
// ----------------------------------------------------------------------------
module dlt_entry_mem #(
  parameter  int LEASE_COUNT = dlt_pkg::LEASE_COUNT_DEFAULT,
  localparam int IDX_W       = (LEASE_COUNT > 1) ? $clog2(LEASE_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dlt_pkg::mem_ctl_t    ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  dlt_pkg::entry_t      wr_data,
  output dlt_pkg::entry_t      rd_data
);
  import dlt_pkg::*;

  localparam entry_t EMPTY_ENTRY = '{key: '0, expiry: '0, status: ST_AVAIL, host: '0};

  entry_t                 mem [LEASE_COUNT];
  entry_t                 rd_word;
  logic [LEASE_COUNT-1:0] live;
  logic                   rd_live;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        live[wr_addr] <= ctl.wr_live;
      end
      if (ctl.rd_en) begin
        rd_live <= live[rd_addr];
      end
    end
  end

  assign rd_data = rd_live ? rd_word : EMPTY_ENTRY;

endmodule

>>> rtl/dlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_ctrl
// Sequencer: key scan, expiry sweep with free-entry search, lease update
// and the output register.
// ----------------------------------------------------------------------------
module dlt_ctrl #(
  parameter  int LEASE_COUNT = dlt_pkg::LEASE_COUNT_DEFAULT,
  localparam int IDX_W       = (LEASE_COUNT > 1) ? $clog2(LEASE_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dlt_pkg::CFG_W-1:0]     server_address,
  input  logic [dlt_pkg::CFG_W-1:0]     offer_hold,
  input  logic [dlt_pkg::CFG_W-1:0]     lease_span,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          is_request,
  input  logic                          has_type,
  input  logic [dlt_pkg::MSG_W-1:0]     message_code,
  input  logic [dlt_pkg::KEY_W-1:0]     mac_key,
  input  logic [dlt_pkg::KEY_W-1:0]     host_key,
  input  logic [dlt_pkg::TIME_W-1:0]    now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dlt_pkg::KIND_W-1:0]    reply_kind,
  output logic                          lease_valid,
  output logic [dlt_pkg::LIDX_W-1:0]    lease_index,
  output logic [dlt_pkg::CFG_W-1:0]     client_address,
  output dlt_pkg::mem_ctl_t             mem_ctl,
  output logic [IDX_W-1:0]              mem_rd_addr,
  output logic [IDX_W-1:0]              mem_wr_addr,
  output dlt_pkg::entry_t               mem_wr_data,
  input  dlt_pkg::entry_t               mem_rd_data,
  output dlt_pkg::alu_op_t              alu_op,
  output logic [dlt_pkg::TIME_W-1:0]    alu_a,
  output logic [dlt_pkg::TIME_W-1:0]    alu_b,
  input  dlt_pkg::alu_res_t             alu_res
);
  import dlt_pkg::*;

  localparam int CNT_W = $clog2(LEASE_COUNT + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_CLEAR   = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  issue_cnt;
  logic              chk_live;
  logic [IDX_W-1:0]  chk_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_hit;
  logic [IDX_W-1:0]  free_idx;

  logic [MSG_W-1:0]  cur_msg;
  logic [KEY_W-1:0]  cur_mac;
  logic [KEY_W-1:0]  cur_host;
  logic [TIME_W-1:0] cur_now;

  logic [KIND_W-1:0] res_kind;
  logic              res_valid;
  logic [LIDX_W-1:0] res_index;
  logic [CFG_W-1:0]  res_addr;

  logic              scanning;
  logic              scan_done;
  logic              rd_en;
  logic              last_chk;
  logic              is_disc;
  logic              is_req;
  logic              have;
  logic [IDX_W-1:0]  sel_idx;
  logic [KIND_W-1:0] kind;
  logic [7:0]        addr_low;

  assign in_stall  = (state != ST_IDLE);
  assign scanning  = (state == ST_SCAN) || (state == ST_CLEAR);
  assign rd_en     = scanning && (issue_cnt != CNT_W'(LEASE_COUNT));
  assign last_chk  = (chk_idx == IDX_W'(LEASE_COUNT - 1));
  assign scan_done = (state == ST_SCAN) && chk_live && !alu_res.flag && last_chk;

  assign is_disc  = (cur_msg == MSG_DISCOVER);
  assign is_req   = (cur_msg == MSG_REQUEST);
  assign have     = hit || (is_disc && free_hit);
  assign sel_idx  = hit ? hit_idx : free_idx;
  assign addr_low = server_address[7:0] + 8'(sel_idx) + 8'd1;

  always_comb begin
    if (is_disc && have) begin
      kind = KIND_OFFER;
    end else if (is_req && hit) begin
      kind = KIND_ACK;
    end else begin
      kind = KIND_NACK;
    end
  end

  // The shared unit compares keys during the scan, expiry times during
  // the sweep and forms the new expiry when the lease is updated.
  always_comb begin
    alu_op = ALU_EQ;
    alu_a  = TIME_W'(mem_rd_data.key);
    alu_b  = TIME_W'(cur_mac);
    case (state)
      ST_CLEAR: begin
        alu_op = ALU_LT;
        alu_a  = mem_rd_data.expiry;
        alu_b  = cur_now;
      end
      ST_RESOLVE: begin
        alu_op = ALU_SAT;
        alu_a  = cur_now;
        alu_b  = is_disc ? TIME_W'(offer_hold) : TIME_W'(lease_span);
      end
      default: begin
        alu_op = ALU_EQ;
      end
    endcase
  end

  always_comb begin
    mem_ctl.rd_en   = rd_en;
    mem_ctl.wr_en   = 1'b0;
    mem_ctl.wr_live = 1'b0;
    mem_rd_addr     = issue_cnt[IDX_W-1:0];
    mem_wr_addr     = chk_idx;
    mem_wr_data     = '0;
    case (state)
      ST_CLEAR: begin
        // An expired entry returns to the free pool.
        mem_ctl.wr_en = chk_live && alu_res.flag;
      end
      ST_RESOLVE: begin
        mem_ctl.wr_en      = (kind != KIND_NACK);
        mem_ctl.wr_live    = 1'b1;
        mem_wr_addr        = sel_idx;
        mem_wr_data.key    = cur_mac;
        mem_wr_data.expiry = alu_res.sum;
        mem_wr_data.status = (kind == KIND_ACK) ? ST_ACK : ST_OFFER;
        mem_wr_data.host   = (kind == KIND_ACK) ? cur_host : '0;
      end
      default: begin
        mem_ctl.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      chk_live  <= 1'b0;
      hit       <= 1'b0;
      free_hit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      if (scanning) begin
        // A key scan that ends without a hit restarts the reads for the sweep.
        if (scan_done) begin
          issue_cnt <= '0;
          chk_live  <= 1'b0;
        end else begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          chk_live <= rd_en;
        end
        chk_idx <= issue_cnt[IDX_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_msg   <= message_code;
            cur_mac   <= mac_key;
            cur_host  <= host_key;
            cur_now   <= now;
            hit       <= 1'b0;
            free_hit  <= 1'b0;
            issue_cnt <= '0;
            chk_live  <= 1'b0;
            // A message that is not a boot request with a type gets no reply.
            if (is_request && has_type) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (chk_live) begin
            if (alu_res.flag) begin
              hit     <= 1'b1;
              hit_idx <= chk_idx;
              state   <= ST_RESOLVE;
            end else if (last_chk) begin
              state <= ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          if (chk_live) begin
            if ((alu_res.flag || (mem_rd_data.key == '0)) && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= chk_idx;
            end
            if (last_chk) begin
              state <= ST_RESOLVE;
            end
          end
        end
        ST_RESOLVE: begin
          res_kind  <= kind;
          res_valid <= have;
          res_index <= have ? LIDX_W'(sel_idx) : '0;
          res_addr  <= have ? {server_address[CFG_W-1:8], addr_low} : '0;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            reply_kind     <= res_kind;
            lease_valid    <= res_valid;
            lease_index    <= res_index;
            client_address <= res_addr;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
